// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level to check its own behaviour.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IUTX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define IUTX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/iutx_pkg.sv =====
// Package with the constants and helpers of the inverted serial transmitter.
package iutx_pkg;

  // Queue geometry.
  localparam int unsigned QUEUE_DEPTH = 128;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned BIT_IDX_W   = $clog2(BYTE_W);

  // Frame and status fields.
  localparam int unsigned FRAME_LEN = 10;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned PEAK_W    = 7;
  localparam int unsigned PEAK_MAX  = 127;
  localparam int unsigned OUT_W     = 16;

  // Configuration port.
  localparam int unsigned APB_AW        = 3;
  localparam int unsigned REG_TX_ENABLE = 0;

  // Input item kinds carried in tuser.
  localparam logic MODE_ENQUEUE = 1'b0;
  localparam logic MODE_TICK    = 1'b1;

  // Ring pointer increment, wrapping at the queue depth.
  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/iutx_ram.sv =====
// Generic single-write, single-read synchronous RAM with write-to-read forwarding.
module iutx_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; a write to the same entry in the same cycle is forwarded.
  // The read register holds its value until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

// ===== rtl/iutx_apb.sv =====
// Configuration register file of the transmitter, written over an APB-style port.
module iutx_apb (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [iutx_pkg::APB_AW-1:0]      paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output logic                             tx_enable
);

  logic reg_hit;
  logic wr_strobe;

  // Registers sit on 32-bit word boundaries; the low address bits are ignored.
  assign reg_hit   = (paddr[iutx_pkg::APB_AW-1:2] ==
                      (iutx_pkg::APB_AW - 2)'(iutx_pkg::REG_TX_ENABLE));
  assign pready    = 1'b1;
  assign wr_strobe = psel && penable && pwrite && pready;

  // Enable register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_enable <= 1'b0;
    end else if (wr_strobe && reg_hit) begin
      tx_enable <= pwdata[0];
    end
  end

  // Read back; addresses beyond the register list read as zero.
  assign prdata = reg_hit ? {31'b0, tx_enable} : 32'b0;

endmodule

// ===== rtl/inverted_uart_tx_with_fifo.sv =====
// Top level of the inverted-frame serial transmitter with its byte ring queue.
//
// Input channel (s_*): each transaction is either a byte to queue (tuser = 0)
// or one bit-period tick (tuser = 1). Every accepted transaction produces
// exactly one result transaction on the output channel (m_*), which shows the
// status after that item: line level, timer state, overflow flag and peak
// queue occupancy.
// Frames are a start bit of 1, the data bits inverted LSB first, a stop bit of 0.
// Throughput is one item per cycle while the receiver takes results. A result
// appears on m_tvalid in the cycle after its input transaction, from the single output register.
// The queued bytes live in a synchronous RAM; a popped byte is read into the
// RAM read register and the frame is driven straight from it, so the start
// bit (which needs no data) covers the registered RAM read.
// When the receiver stalls, the result waits in the output register and the
// input accepts a transaction only in a cycle in which that register is empty
// or being emptied, so back-pressure reaches the sender in the same cycle.
// Reset clears pointers, flags, peak and frame state at once; the queue RAM
// needs no clearing pass, so the block accepts items from the first cycle.
// The enable register (byte address 0) must be set before items have effect.
`include "assert_macros.svh"

module inverted_uart_tx_with_fifo (
  input  logic                        clk,
  input  logic                        rst,
  // Input stream.
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // [7:0] data_byte
  input  logic                        s_tuser,   // [0] mode
  // Result stream.
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [15:0]                 m_tdata,   // [0] line_level, [1] tick_running,
                                                 // [2] overflow_seen, [9:3] peak_entries
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [iutx_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  // Control state.
  logic [iutx_pkg::PTR_W-1:0]     rd_ptr, rd_ptr_next;
  logic [iutx_pkg::PTR_W-1:0]     wr_ptr, wr_ptr_next;
  logic [iutx_pkg::POS_W-1:0]     bit_pos, bit_pos_next;
  logic                           pin_level, pin_level_next;
  logic                           timer_on, timer_on_next;
  logic                           overflow_flag, overflow_flag_next;
  logic [iutx_pkg::PEAK_W-1:0]    peak_count, peak_count_next;

  // Datapath signals.
  logic                           tx_enable;
  logic                           in_xact;
  logic                           step;
  logic                           idle;
  logic                           queue_full;
  logic                           queue_empty;
  logic [iutx_pkg::PTR_W-1:0]     wr_ptr_inc;
  logic [iutx_pkg::PTR_W-1:0]     rd_ptr_inc;
  logic [iutx_pkg::PTR_W-1:0]     rd_ptr_after;
  logic [iutx_pkg::PTR_W:0]       occ_diff;
  logic [iutx_pkg::PTR_W-1:0]     occ;
  logic [iutx_pkg::PEAK_W-1:0]    occ_sat;
  logic                           wr_en;
  logic                           rd_en;
  logic [iutx_pkg::BYTE_W-1:0]    frame_byte;
  logic [iutx_pkg::POS_W-1:0]     pos_m1;
  logic                           frame_bit;

  // Configuration registers.
  iutx_apb u_apb (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .tx_enable (tx_enable)
  );

  // Byte queue storage.
  iutx_ram #(
    .DEPTH (iutx_pkg::QUEUE_DEPTH),
    .WIDTH (iutx_pkg::BYTE_W)
  ) u_queue (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_ptr),
    .wdata (s_tdata),
    .re    (rd_en),
    .raddr (rd_ptr),
    .rdata (frame_byte)
  );

  // Input handshake: accept whenever the result register is free or draining.
  assign s_tready = !m_tvalid || m_tready;
  assign in_xact  = s_tvalid && s_tready;
  assign step     = in_xact && tx_enable;

  // Queue and frame status.
  assign wr_ptr_inc  = iutx_pkg::next_ptr(wr_ptr);
  assign rd_ptr_inc  = iutx_pkg::next_ptr(rd_ptr);
  assign queue_full  = (wr_ptr_inc == rd_ptr);
  assign queue_empty = (wr_ptr == rd_ptr);
  assign idle        = (bit_pos >= iutx_pkg::POS_W'(iutx_pkg::FRAME_LEN));

  // Occupancy after a successful enqueue, wrapped modulo the queue depth.
  assign rd_ptr_after = idle ? rd_ptr_inc : rd_ptr;
  assign occ_diff     = {1'b0, wr_ptr_inc} - {1'b0, rd_ptr_after};
  assign occ          = occ_diff[iutx_pkg::PTR_W]
                        ? iutx_pkg::PTR_W'(occ_diff + (iutx_pkg::PTR_W + 1)'(iutx_pkg::QUEUE_DEPTH))
                        : occ_diff[iutx_pkg::PTR_W-1:0];
  assign occ_sat      = (32'(occ) > iutx_pkg::PEAK_MAX)
                        ? iutx_pkg::PEAK_W'(iutx_pkg::PEAK_MAX)
                        : iutx_pkg::PEAK_W'(occ);

  // Frame bit at the current position: start bit, inverted data, stop bit.
  assign pos_m1 = bit_pos - iutx_pkg::POS_W'(1);
  always_comb begin
    priority if (bit_pos == '0) begin
      frame_bit = 1'b1;
    end else if (bit_pos == iutx_pkg::POS_W'(iutx_pkg::FRAME_LEN - 1)) begin
      frame_bit = 1'b0;
    end else begin
      frame_bit = ~frame_byte[pos_m1[iutx_pkg::BIT_IDX_W-1:0]];
    end
  end

  // Next-state logic for one accepted item while transmission is enabled.
  always_comb begin
    wr_en              = 1'b0;
    rd_en              = 1'b0;
    rd_ptr_next        = rd_ptr;
    wr_ptr_next        = wr_ptr;
    bit_pos_next       = bit_pos;
    pin_level_next     = pin_level;
    timer_on_next      = timer_on;
    overflow_flag_next = overflow_flag;
    peak_count_next    = peak_count;
    if (step) begin
      if (s_tuser == iutx_pkg::MODE_ENQUEUE) begin
        if (queue_full) begin
          overflow_flag_next = 1'b1;
        end else begin
          wr_en       = 1'b1;
          wr_ptr_next = wr_ptr_inc;
          // An idle transmitter pops the oldest byte straight away.
          if (idle) begin
            rd_en         = 1'b1;
            rd_ptr_next   = rd_ptr_inc;
            bit_pos_next  = '0;
            timer_on_next = 1'b1;
          end
          if (occ_sat > peak_count) begin
            peak_count_next = occ_sat;
          end
        end
      end else begin
        if (!idle) begin
          pin_level_next = frame_bit;
          bit_pos_next   = bit_pos + iutx_pkg::POS_W'(1);
          timer_on_next  = 1'b1;
        end else if (!queue_empty) begin
          rd_en         = 1'b1;
          rd_ptr_next   = rd_ptr_inc;
          bit_pos_next  = '0;
          timer_on_next = 1'b1;
        end else begin
          timer_on_next = 1'b0;
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr        <= '0;
      wr_ptr        <= '0;
      bit_pos       <= iutx_pkg::POS_W'(iutx_pkg::FRAME_LEN);
      pin_level     <= 1'b0;
      timer_on      <= 1'b0;
      overflow_flag <= 1'b0;
      peak_count    <= '0;
    end else begin
      rd_ptr        <= rd_ptr_next;
      wr_ptr        <= wr_ptr_next;
      bit_pos       <= bit_pos_next;
      pin_level     <= pin_level_next;
      timer_on      <= timer_on_next;
      overflow_flag <= overflow_flag_next;
      peak_count    <= peak_count_next;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_xact) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Result payload: the status after the accepted item.
  always_ff @(posedge clk) begin
    if (in_xact) begin
      m_tdata <= iutx_pkg::OUT_W'({peak_count_next, overflow_flag_next,
                                   timer_on_next, pin_level_next});
    end
  end

  // Design checks.
  `IUTX_ASSERT_IMP(a_no_write_when_full, wr_en, !queue_full,
                   "queue written while full")
  `IUTX_ASSERT_NXT(a_overflow_sticky, overflow_flag, overflow_flag,
                   "overflow flag cleared outside reset")
  `IUTX_ASSERT_NXT(a_idle_tick_stops,
                   step && (s_tuser == iutx_pkg::MODE_TICK) && idle && queue_empty,
                   !timer_on, "timer still running with nothing left to send")
  `IUTX_ASSERT_NXT(a_pop_starts_frame, rd_en, (bit_pos == '0) && timer_on,
                   "byte popped without starting a frame")

endmodule
